### sv/icmc_pkg.sv
// ----------------------------------------------------------------------------
// icmc_pkg
// Shared constants, address field widths and control types for the
// instruction cache miss counter.
// ----------------------------------------------------------------------------
`default_nettype none

package icmc_pkg;

   localparam int LINE_WORDS = 4;
   localparam int LINES      = 4;
   localparam int WAYS       = 4;
   localparam int DEPTH      = (LINES > WAYS) ? LINES : WAYS;

   localparam int PC_W    = 32;
   localparam int COUNT_W = 32;
   localparam int MODE_W  = 2;
   localparam int WORD_W  = PC_W - 2;
   localparam int KEY_W   = WORD_W - $clog2(LINE_WORDS);
   localparam int TAG_W   = KEY_W - $clog2(LINES);
   localparam int IDX_W   = (LINES > 1) ? $clog2(LINES) : 1;

   localparam logic [MODE_W-1:0] MODE_DIRECT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ASSOC   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GROUPED = 2'd2;

   typedef struct packed {
      logic clear;
      logic shift;
      logic flush;
   } icmc_ctl_type;

endpackage

`default_nettype wire

### sv/icmc_req_if.sv
// ----------------------------------------------------------------------------
// icmc_req_if
// Fetch address channel: valid/ready handshake carrying one pc per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface icmc_req_if;
   logic                        valid;
   logic                        ready;
   logic [icmc_pkg::PC_W-1:0]   pc;

   modport source (output valid, output pc, input ready);
   modport sink   (input valid, input pc, output ready);
endinterface

`default_nettype wire

### sv/icmc_rsp_if.sv
// ----------------------------------------------------------------------------
// icmc_rsp_if
// Result channel: valid/ready handshake carrying hit flag and miss count.
// ----------------------------------------------------------------------------
`default_nettype none

interface icmc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [icmc_pkg::COUNT_W-1:0]  miss_count;

   modport source (output valid, output hit, output miss_count, input ready);
   modport sink   (input valid, input hit, input miss_count, output ready);
endinterface

`default_nettype wire

### sv/icmc_cell.sv
// ----------------------------------------------------------------------------
// icmc_cell
// One tag cell of the replacement chain. Holds an associative entry that
// advances to the next cell on each fill, and one direct-mode line valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module icmc_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire icmc_pkg::icmc_ctl_type       ctl,
   input  wire logic [icmc_pkg::KEY_W-1:0]   key,
   input  wire logic                         keep,
   input  wire logic                         set_line,
   input  wire logic [icmc_pkg::KEY_W-1:0]   prev_tag,
   input  wire logic                         prev_valid,
   output      logic [icmc_pkg::KEY_W-1:0]   tag_out,
   output      logic                         valid_out,
   output      logic                         match,
   output      logic                         line_hit
);

   logic [icmc_pkg::KEY_W-1:0] tag_ff;
   logic [icmc_pkg::KEY_W-1:0] tag_in;
   logic                       valid_ff;
   logic                       valid_in;
   logic                       line_ff;
   logic                       line_in;

   always_comb begin
      tag_in   = tag_ff;
      valid_in = valid_ff;
      line_in  = line_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
         line_in  = 1'b0;
      end else begin
         if (ctl.shift) begin
            tag_in   = prev_tag;
            valid_in = prev_valid & keep;
         end
         line_in = (line_ff & ~ctl.flush) | set_line;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      if (reset) begin
         valid_ff <= 1'b0;
         line_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         line_ff  <= line_in;
      end
   end

   assign tag_out   = tag_ff;
   assign valid_out = valid_ff;
   assign match     = valid_ff && (tag_ff == key);
   assign line_hit  = line_ff & set_line;

endmodule

`default_nettype wire

### sv/instruction_cache_miss_counter.sv
// ----------------------------------------------------------------------------
// instruction_cache_miss_counter
// Instruction cache hit/miss model with a running miss count.
//
// req_bus carries one fetch address (pc) per word; rsp_bus returns one word
// per address with the hit flag and the wrapping miss count including it.
// csr_we/csr_wdata write the cache mode (0 direct with shared tag, 1 fully
// associative FIFO, 2 or 3 grouped FIFO); a write clears all valid bits and
// the shared tag but keeps the miss count. Write only while idle.
//
// The result is registered in the cycle after accept. Throughput is one address
// per cycle unless the receiver stalls: all tag compares run in parallel
// across the cell chain, and a miss inserts at the head while older entries
// advance one cell, so the oldest entry drops out of the last active cell.
//
// Reset selects grouped mode, clears all valid bits, the shared tag and the
// miss count. When the receiver stalls the result register holds and
// req_bus.ready drops until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module instruction_cache_miss_counter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   icmc_req_if.sink                           req_bus,
   icmc_rsp_if.source                         rsp_bus,
   input  wire logic                          csr_we,
   input  wire logic [icmc_pkg::MODE_W-1:0]   csr_wdata
);

   logic [icmc_pkg::MODE_W-1:0]  mode_ff;
   logic [icmc_pkg::TAG_W-1:0]   shared_tag_ff;
   logic [icmc_pkg::TAG_W-1:0]   shared_tag_in;
   logic [icmc_pkg::COUNT_W-1:0] miss_ff;
   logic [icmc_pkg::COUNT_W-1:0] miss_in;
   logic                         rsp_valid_ff;
   logic                         rsp_hit_ff;

   logic                         accept;
   logic [icmc_pkg::WORD_W-1:0]  word;
   logic [icmc_pkg::KEY_W-1:0]   line;
   logic [icmc_pkg::TAG_W-1:0]   tag;
   logic [icmc_pkg::IDX_W-1:0]   index;
   logic [icmc_pkg::KEY_W-1:0]   key;
   logic                         is_direct;
   logic                         is_assoc;
   logic                         tag_same;
   logic                         hit;
   icmc_pkg::icmc_ctl_type       ctl;

   logic [icmc_pkg::KEY_W-1:0]   chain_tag [icmc_pkg::DEPTH];
   logic [icmc_pkg::DEPTH-1:0]   chain_valid;
   logic [icmc_pkg::DEPTH-1:0]   match;
   logic [icmc_pkg::DEPTH-1:0]   line_hit;

   assign accept    = req_bus.valid && req_bus.ready;
   assign word      = req_bus.pc[icmc_pkg::PC_W-1:2];
   assign line      = icmc_pkg::KEY_W'(word / icmc_pkg::LINE_WORDS);
   assign tag       = icmc_pkg::TAG_W'(line / icmc_pkg::LINES);
   assign index     = icmc_pkg::IDX_W'(line % icmc_pkg::LINES);
   assign is_direct = (mode_ff == icmc_pkg::MODE_DIRECT);
   assign is_assoc  = (mode_ff == icmc_pkg::MODE_ASSOC);
   assign key       = is_assoc ? line : icmc_pkg::KEY_W'(tag);
   assign tag_same  = (tag == shared_tag_ff);

   always_comb begin
      if (is_direct) begin
         hit = tag_same && (|line_hit);
      end else begin
         hit = |match;
      end
      ctl.clear = csr_we;
      ctl.shift = accept && !is_direct && !hit;
      ctl.flush = accept && is_direct && !tag_same;
   end

   for (genvar i = 0; i < icmc_pkg::DEPTH; i++) begin : g_cell
      logic [icmc_pkg::KEY_W-1:0] prev_tag;
      logic                       prev_valid;
      logic                       keep;
      logic                       set_line;

      if (i == 0) begin : g_head
         assign prev_tag   = key;
         assign prev_valid = 1'b1;
      end else begin : g_link
         assign prev_tag   = chain_tag[i-1];
         assign prev_valid = chain_valid[i-1];
      end

      assign keep = is_assoc ? (i < icmc_pkg::LINES) : (i < icmc_pkg::WAYS);

      if (i < icmc_pkg::LINES) begin : g_line
         assign set_line = accept && is_direct && (index == icmc_pkg::IDX_W'(i));
      end else begin : g_noline
         assign set_line = 1'b0;
      end

      icmc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key        (key),
         .keep       (keep),
         .set_line   (set_line),
         .prev_tag   (prev_tag),
         .prev_valid (prev_valid),
         .tag_out    (chain_tag[i]),
         .valid_out  (chain_valid[i]),
         .match      (match[i]),
         .line_hit   (line_hit[i])
      );
   end

   always_comb begin
      shared_tag_in = shared_tag_ff;
      miss_in       = miss_ff;
      if (csr_we) begin
         shared_tag_in = '0;
      end else if (ctl.flush) begin
         shared_tag_in = tag;
      end
      if (accept && !hit) begin
         miss_in = miss_ff + icmc_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= icmc_pkg::MODE_GROUPED;
         shared_tag_ff <= '0;
         miss_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         shared_tag_ff <= shared_tag_in;
         miss_ff       <= miss_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff <= hit;
      end
   end

   assign req_bus.ready      = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hit        = rsp_hit_ff;
   assign rsp_bus.miss_count = miss_ff;

endmodule

`default_nettype wire

### tb/tb_instruction_cache_miss_counter.sv
// ----------------------------------------------------------------------------
// tb_instruction_cache_miss_counter
// Self-checking bench for the instruction cache miss counter. Fetch words are
// pushed in random bursts while the result side stalls on a rotating pattern.
// A tracker class mirrors the direct, fully associative and grouped
// organizations, predicts hit and miss count per accepted word and checks
// every returned word in order. The mode is rewritten between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_instruction_cache_miss_counter;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 11;
   localparam int HOLD_CYCLES    = 64;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int POOL_DEPTH     = 8;

   localparam logic [icmc_pkg::MODE_W-1:0] MODE_GROUPED_ALT = 2'd3;

   typedef struct {
      bit                         hit;
      bit [icmc_pkg::COUNT_W-1:0] miss_count;
   } fetch_result_type;

   class miss_tracker_type;
      bit [icmc_pkg::MODE_W-1:0]  mode;
      bit [icmc_pkg::KEY_W-1:0]   keys [icmc_pkg::DEPTH];
      bit                         key_live [icmc_pkg::DEPTH];
      int unsigned                fifo_ptr;
      bit [icmc_pkg::TAG_W-1:0]   shared_tag;
      bit                         line_live [icmc_pkg::LINES];
      bit [icmc_pkg::COUNT_W-1:0] misses;
      fetch_result_type           predicted [$];
      int                         mismatches;
      int                         compared;
      int                         hits_seen;

      function new();
         mode       = icmc_pkg::MODE_GROUPED;
         misses     = '0;
         mismatches = 0;
         compared   = 0;
         hits_seen  = 0;
         clear_stores();
      endfunction

      function void clear_stores();
         foreach (key_live[i]) key_live[i] = 1'b0;
         foreach (keys[i]) keys[i] = '0;
         foreach (line_live[i]) line_live[i] = 1'b0;
         fifo_ptr   = 0;
         shared_tag = '0;
      endfunction

      function void set_mode(bit [icmc_pkg::MODE_W-1:0] m);
         mode = m;
         clear_stores();
      endfunction

      function int pending();
         return predicted.size();
      endfunction

      function bit fifo_lookup(bit [icmc_pkg::KEY_W-1:0] key, int unsigned ways);
         for (int i = 0; i < ways; i++)
            if (key_live[i] && keys[i] == key) return 1'b1;
         if (fifo_ptr >= ways) fifo_ptr = 0;
         keys[fifo_ptr]     = key;
         key_live[fifo_ptr] = 1'b1;
         fifo_ptr = (fifo_ptr + 1 >= ways) ? 0 : fifo_ptr + 1;
         return 1'b0;
      endfunction

      function void note_fetch(bit [icmc_pkg::PC_W-1:0] pc);
         bit [icmc_pkg::PC_W-1:0]  line;
         int unsigned              idx;
         bit [icmc_pkg::TAG_W-1:0] tag;
         bit                       hit;
         fetch_result_type         r;
         line = (pc >> 2) / icmc_pkg::LINE_WORDS;
         idx  = line % icmc_pkg::LINES;
         tag  = line / icmc_pkg::LINES;
         case (mode)
            icmc_pkg::MODE_DIRECT: begin
               if (tag != shared_tag) begin
                  foreach (line_live[i]) line_live[i] = 1'b0;
                  shared_tag = tag;
               end
               hit = line_live[idx];
               line_live[idx] = 1'b1;
            end
            icmc_pkg::MODE_ASSOC: begin
               hit = fifo_lookup(icmc_pkg::KEY_W'(line), icmc_pkg::LINES);
            end
            default: begin
               hit = fifo_lookup(icmc_pkg::KEY_W'(tag), icmc_pkg::WAYS);
            end
         endcase
         if (!hit) misses++;
         r.hit        = hit;
         r.miss_count = misses;
         predicted.push_back(r);
      endfunction

      function void check_result(logic hit, logic [icmc_pkg::COUNT_W-1:0] count);
         fetch_result_type want;
         if (predicted.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word, hit %0d miss_count %0d", $time, hit, count);
            return;
         end
         want = predicted.pop_front();
         compared++;
         if (want.hit) hits_seen++;
         if (hit !== want.hit) begin
            mismatches++;
            $display("%0t: hit expected %0d actual %0d", $time, want.hit, hit);
         end
         if (count !== want.miss_count) begin
            mismatches++;
            $display("%0t: miss_count expected %0d actual %0d",
                     $time, want.miss_count, count);
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_we;
   logic [icmc_pkg::MODE_W-1:0]   csr_wdata;

   icmc_req_if req_bus ();
   icmc_rsp_if rsp_bus ();

   instruction_cache_miss_counter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   miss_tracker_type         tracker;
   bit [icmc_pkg::TAG_W-1:0] tag_pool [POOL_DEPTH];
   int                       burst_left;
   int                       fetches_sent;
   int                       hold_requests;
   int                       hold_served;
   int                       idle_cycles;

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_result(rsp_bus.hit, rsp_bus.miss_count);
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("instruction_cache_miss_counter: mismatch");
         $finish;
      end
   end

   // result side: rotating stall pattern, or a long hold-off on request
   initial begin
      bit [15:0] stall_pattern;
      int        pattern_age;
      stall_pattern = 16'hffff;
      pattern_age   = 0;
      hold_served   = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_served++;
         end else begin
            rsp_bus.ready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            pattern_age++;
            if (pattern_age == 48) begin
               pattern_age = 0;
               if ($urandom_range(0, 3) == 0)
                  stall_pattern = 16'hffff;
               else
                  stall_pattern = 16'($urandom) | 16'h0001;
            end
         end
      end
   end

   function automatic bit [icmc_pkg::PC_W-1:0] pick_fetch_pc(int pool_size);
      bit [icmc_pkg::PC_W-1:0] line;
      if ($urandom_range(0, 7) == 0) return $urandom;
      line = icmc_pkg::PC_W'(tag_pool[$urandom_range(0, pool_size - 1)]) * icmc_pkg::LINES
             + $urandom_range(0, icmc_pkg::LINES - 1);
      return (line * icmc_pkg::LINE_WORDS + $urandom_range(0, icmc_pkg::LINE_WORDS - 1)) * 4
             + $urandom_range(0, 3);
   endfunction

   function automatic void refill_pool();
      foreach (tag_pool[i])
         tag_pool[i] = ($urandom_range(0, 1) == 1)
                       ? icmc_pkg::TAG_W'($urandom_range(0, 3))
                       : icmc_pkg::TAG_W'($urandom >> (icmc_pkg::PC_W - icmc_pkg::TAG_W));
   endfunction

   task automatic send_fetch(input bit [icmc_pkg::PC_W-1:0] pc);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.pc    <= pc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.note_fetch(pc);
      fetches_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_mode(input bit [icmc_pkg::MODE_W-1:0] m);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_mode(m);
      @(posedge clock);
   endtask

   task automatic run_random(input int count, input int pool_size);
      refill_pool();
      for (int i = 0; i < count; i++)
         send_fetch(pick_fetch_pc(pool_size));
   endtask

   initial begin
      tracker       = new();
      burst_left    = 1;
      fetches_sent  = 0;
      hold_requests = 0;
      idle_cycles   = 0;
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_wdata     <= '0;
      req_bus.valid <= 1'b0;
      req_bus.pc    <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // grouped mode out of reset: cold ways must not match tag zero
      send_fetch(32'h0000_0000);
      send_fetch(32'h0000_0000);
      send_fetch(32'h0000_0003);
      send_fetch(32'h0000_0010);
      send_fetch(32'h0000_0040);
      send_fetch(32'hffff_ffff);
      send_fetch(32'hffff_fffc);
      send_fetch(32'h0000_0080);
      send_fetch(32'h0000_00c0);
      send_fetch(32'h0000_0000);
      run_random(60, 6);

      write_mode(icmc_pkg::MODE_DIRECT);
      send_fetch(32'h0000_0000);
      send_fetch(32'h0000_0010);
      send_fetch(32'h0000_0004);
      send_fetch(32'h0000_0040);
      send_fetch(32'h0000_0000);
      send_fetch(32'hffff_fffc);
      run_random(45, 2);
      drain_results();
      run_random(45, 2);

      write_mode(icmc_pkg::MODE_ASSOC);
      send_fetch(32'h0000_0000);
      send_fetch(32'h0000_0010);
      send_fetch(32'h0000_0020);
      send_fetch(32'h0000_0030);
      send_fetch(32'h0000_0040);
      send_fetch(32'h0000_0000);
      run_random(10, 2);
      hold_requests++;
      run_random(80, 2);

      write_mode(MODE_GROUPED_ALT);
      run_random(60, 6);
      write_mode(icmc_pkg::MODE_GROUPED);
      run_random(60, 6);
      write_mode(icmc_pkg::MODE_DIRECT);
      run_random(40, 2);

      drain_results();
      repeat (4) @(posedge clock);
      $display("%0d fetch words sent over direct, fully associative and grouped modes",
               fetches_sent);
      $display("%0d results compared, %0d hits, %0d long receiver hold-offs",
               tracker.compared, tracker.hits_seen, hold_served);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("instruction_cache_miss_counter: match");
      else
         $display("instruction_cache_miss_counter: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
